/* hdl/bcu_pkg.sv */
// Shared types and constants for the barometric compensation unit.
`timescale 1ns / 1ps
package bcu_pkg;

  typedef enum logic [2:0] {
    REG_AC1 = 3'd0,
    REG_AC2 = 3'd1,
    REG_AC3 = 3'd2,
    REG_AC4 = 3'd3,
    REG_AC5 = 3'd4,
    REG_AC6 = 3'd5,
    REG_B   = 3'd6,
    REG_M   = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_DIV,
    ST_P_SQ,
    ST_P_X1,
    ST_P_X2,
    ST_P_X1B,
    ST_P_X2B,
    ST_P_B4,
    ST_P_B7,
    ST_P_DIV,
    ST_P_Y1A,
    ST_P_Y1B,
    ST_P_Y2,
    ST_DONE
  } state_t;

  localparam logic [31:0] B6_OFFSET = 32'd4000;
  localparam logic [31:0] PY1_GAIN  = 32'd3038;
  localparam logic [31:0] PY2_GAIN  = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] PY_BIAS   = 32'd3791;
  localparam logic [31:0] B4_BIAS   = 32'd32768;
  localparam logic [31:0] B7_BASE   = 32'd50000;

endpackage

/* hdl/barometric_sensor_compensation_unit.sv */
// Top level: calibration registers, conversion sequencer and result register.
`timescale 1ns / 1ps
// Takes one word at a time: a temperature conversion (cmd 0) or a pressure
// conversion (cmd 1) and returns one result word. All arithmetic runs through
// one bit-serial unit: a temperature word takes one multiply and one divide,
// a pressure word ten multiplies and one divide. The input stalls from
// acceptance until the result sits in the output register. A pressure word
// uses the temperature term of the last good temperature word (zero after
// reset). Zero divisors give div_error and value 0.
module barometric_sensor_compensation_unit #(
  parameter int OVERSAMPLING = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [18:0]        in_raw_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [23:0] out_value,
  output logic               out_div_error
);

  localparam logic [31:0] B7_SCALE = bcu_pkg::B7_BASE >> OVERSAMPLING;

  logic [15:0] ac1_r, ac2_r, ac3_r, ac4_r, ac5_r, ac6_r;
  logic [31:0] b_r, m_r;
  logic [31:0] temp_term_r, temp_term_nxt;

  bcu_pkg::state_t state_r, state_nxt;
  logic        issued_r, issued_nxt;
  logic        cmd_r, cmd_nxt;
  logic [18:0] raw_r, raw_nxt;
  logic [31:0] x1_r, x1_nxt;
  logic [31:0] b6_r, b6_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [31:0] s1_r, s1_nxt;
  logic [31:0] b3_r, b3_nxt;
  logic [31:0] b4_r, b4_nxt;
  logic [31:0] b7_r, b7_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] y1_r, y1_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic        res_err_r, res_err_nxt;
  logic [23:0] res_val_r, res_val_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [23:0] out_value_r, out_value_nxt;
  logic        out_err_r, out_err_nxt;

  bcu_pkg::alu_req_t alu_req;
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_done;

  logic [31:0] md, mc, b1, b2, ac1, ac2, ac3;
  logic [31:0] den, num, quo, b5, x3, tsh, x3b;
  logic [31:0] y2, psum;

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
    asr = $signed(v) >>> n;
  endfunction

  function automatic logic [23:0] sat24(input logic [31:0] v);
    if ($signed(v) > $signed(32'sd8388607)) sat24 = 24'h7F_FFFF;
    else if ($signed(v) < $signed(-32'sd8388608)) sat24 = 24'h80_0000;
    else sat24 = v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_r <= '0; ac2_r <= '0; ac3_r <= '0;
      ac4_r <= '0; ac5_r <= '0; ac6_r <= '0;
      b_r   <= '0; m_r   <= '0;
    end else if (cfg_we) begin
      case (bcu_pkg::reg_idx_t'(cfg_index))
        bcu_pkg::REG_AC1: ac1_r <= cfg_wdata[15:0];
        bcu_pkg::REG_AC2: ac2_r <= cfg_wdata[15:0];
        bcu_pkg::REG_AC3: ac3_r <= cfg_wdata[15:0];
        bcu_pkg::REG_AC4: ac4_r <= cfg_wdata[15:0];
        bcu_pkg::REG_AC5: ac5_r <= cfg_wdata[15:0];
        bcu_pkg::REG_AC6: ac6_r <= cfg_wdata[15:0];
        bcu_pkg::REG_B:   b_r   <= cfg_wdata;
        bcu_pkg::REG_M:   m_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ac1 = {{16{ac1_r[15]}}, ac1_r};
  assign ac2 = {{16{ac2_r[15]}}, ac2_r};
  assign ac3 = {{16{ac3_r[15]}}, ac3_r};
  assign b1  = {{16{b_r[31]}}, b_r[31:16]};
  assign b2  = {{16{b_r[15]}}, b_r[15:0]};
  assign mc  = {{16{m_r[31]}}, m_r[31:16]};
  assign md  = {{16{m_r[15]}}, m_r[15:0]};

  bcu_serial_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .opa   (alu_a),
    .opb   (alu_b),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    cmd_nxt       = cmd_r;
    raw_nxt       = raw_r;
    x1_nxt        = x1_r;
    b6_nxt        = b6_r;
    sq_nxt        = sq_r;
    s1_nxt        = s1_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    b7_nxt        = b7_r;
    p_nxt         = p_r;
    y1_nxt        = y1_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    dvs_nxt       = dvs_r;
    res_err_nxt   = res_err_r;
    res_val_nxt   = res_val_r;
    temp_term_nxt = temp_term_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    in_stall      = (state_r != bcu_pkg::ST_IDLE);
    alu_req.start = 1'b0;
    alu_req.op    = bcu_pkg::OP_MUL;
    alu_a         = '0;
    alu_b         = '0;

    den  = x1_r + md;
    num  = {mc[20:0], 11'b0};
    quo  = neg_r ? (32'd0 - alu_res) : alu_res;
    b5   = x1_r + quo;
    x3   = s1_r + asr(alu_res, 11);
    tsh  = ({ac1[29:0], 2'b00} + x3) << OVERSAMPLING;
    x3b  = asr(s1_r + asr(alu_res, 16) + 32'd2, 2);
    y2   = asr(alu_res, 16);
    psum = p_r + asr(y1_r + y2 + bcu_pkg::PY_BIAS, 4);

    // operand select for the shared unit
    case (state_r)
      bcu_pkg::ST_T_MUL: begin
        alu_a = {16'b0, raw_r[15:0]} - {16'b0, ac6_r};
        alu_b = {16'b0, ac5_r};
      end
      bcu_pkg::ST_T_DIV: begin
        alu_req.op = bcu_pkg::OP_DIV;
        alu_a = dvd_r;
        alu_b = dvs_r;
      end
      bcu_pkg::ST_P_SQ:  begin alu_a = b6_r; alu_b = b6_r; end
      bcu_pkg::ST_P_X1:  begin alu_a = b2;   alu_b = sq_r; end
      bcu_pkg::ST_P_X2:  begin alu_a = ac2;  alu_b = b6_r; end
      bcu_pkg::ST_P_X1B: begin alu_a = ac3;  alu_b = b6_r; end
      bcu_pkg::ST_P_X2B: begin alu_a = b1;   alu_b = sq_r; end
      bcu_pkg::ST_P_B4:  begin alu_a = {16'b0, ac4_r}; alu_b = s1_r; end
      bcu_pkg::ST_P_B7:  begin alu_a = {13'b0, raw_r} - b3_r; alu_b = B7_SCALE; end
      bcu_pkg::ST_P_DIV: begin
        alu_req.op = bcu_pkg::OP_DIV;
        alu_a = b7_r[31] ? b7_r : {b7_r[30:0], 1'b0};
        alu_b = b4_r;
      end
      bcu_pkg::ST_P_Y1A: begin alu_a = asr(p_r, 8); alu_b = asr(p_r, 8); end
      bcu_pkg::ST_P_Y1B: begin alu_a = y1_r; alu_b = bcu_pkg::PY1_GAIN; end
      bcu_pkg::ST_P_Y2:  begin alu_a = bcu_pkg::PY2_GAIN; alu_b = p_r; end
      default: ;
    endcase

    if (state_r != bcu_pkg::ST_IDLE && state_r != bcu_pkg::ST_DONE && !issued_r) begin
      alu_req.start = 1'b1;
      issued_nxt    = 1'b1;
    end

    case (state_r)
      bcu_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          raw_nxt     = in_raw_sample;
          b6_nxt      = temp_term_r - bcu_pkg::B6_OFFSET;
          res_err_nxt = 1'b0;
          res_val_nxt = '0;
          issued_nxt  = 1'b0;
          state_nxt   = in_cmd ? bcu_pkg::ST_P_SQ : bcu_pkg::ST_T_MUL;
        end
      end
      bcu_pkg::ST_T_MUL: begin
        if (alu_done) begin
          issued_nxt = 1'b0;
          x1_nxt = asr(alu_res, 15);
          state_nxt = bcu_pkg::ST_T_DIV;
        end
      end
      bcu_pkg::ST_T_DIV: begin
        // divisor register settles in the cycle after x1; set up magnitudes on first pass
        if (!issued_r) begin
          alu_req.start = 1'b0;
          issued_nxt = 1'b0;
          if (den == '0) begin
            res_err_nxt = 1'b1;
            state_nxt   = bcu_pkg::ST_DONE;
          end else if (dvs_r != (den[31] ? 32'd0 - den : den) ||
                       dvd_r != (num[31] ? 32'd0 - num : num) ||
                       neg_r != (num[31] ^ den[31])) begin
            neg_nxt = num[31] ^ den[31];
            dvd_nxt = num[31] ? 32'd0 - num : num;
            dvs_nxt = den[31] ? 32'd0 - den : den;
          end else begin
            alu_req.start = 1'b1;
            issued_nxt    = 1'b1;
          end
        end else if (alu_done) begin
          issued_nxt    = 1'b0;
          temp_term_nxt = b5;
          res_val_nxt   = sat24(asr(b5 + 32'd8, 4));
          state_nxt     = bcu_pkg::ST_DONE;
        end
      end
      bcu_pkg::ST_P_SQ: if (alu_done) begin
        issued_nxt = 1'b0; sq_nxt = asr(alu_res, 12); state_nxt = bcu_pkg::ST_P_X1;
      end
      bcu_pkg::ST_P_X1: if (alu_done) begin
        issued_nxt = 1'b0; s1_nxt = asr(alu_res, 11); state_nxt = bcu_pkg::ST_P_X2;
      end
      bcu_pkg::ST_P_X2: if (alu_done) begin
        issued_nxt = 1'b0; b3_nxt = asr(tsh + 32'd2, 2); state_nxt = bcu_pkg::ST_P_X1B;
      end
      bcu_pkg::ST_P_X1B: if (alu_done) begin
        issued_nxt = 1'b0; s1_nxt = asr(alu_res, 13); state_nxt = bcu_pkg::ST_P_X2B;
      end
      bcu_pkg::ST_P_X2B: if (alu_done) begin
        issued_nxt = 1'b0; s1_nxt = x3b + bcu_pkg::B4_BIAS; state_nxt = bcu_pkg::ST_P_B4;
      end
      bcu_pkg::ST_P_B4: if (alu_done) begin
        issued_nxt = 1'b0;
        b4_nxt = {15'b0, alu_res[31:15]};
        if (alu_res[31:15] == '0) begin
          res_err_nxt = 1'b1;
          state_nxt   = bcu_pkg::ST_DONE;
        end else begin
          state_nxt = bcu_pkg::ST_P_B7;
        end
      end
      bcu_pkg::ST_P_B7: if (alu_done) begin
        issued_nxt = 1'b0; b7_nxt = alu_res; state_nxt = bcu_pkg::ST_P_DIV;
      end
      bcu_pkg::ST_P_DIV: if (alu_done) begin
        issued_nxt = 1'b0;
        p_nxt = b7_r[31] ? {alu_res[30:0], 1'b0} : alu_res;
        state_nxt = bcu_pkg::ST_P_Y1A;
      end
      bcu_pkg::ST_P_Y1A: if (alu_done) begin
        issued_nxt = 1'b0; y1_nxt = alu_res; state_nxt = bcu_pkg::ST_P_Y1B;
      end
      bcu_pkg::ST_P_Y1B: if (alu_done) begin
        issued_nxt = 1'b0; y1_nxt = asr(alu_res, 16); state_nxt = bcu_pkg::ST_P_Y2;
      end
      bcu_pkg::ST_P_Y2: if (alu_done) begin
        issued_nxt  = 1'b0;
        res_val_nxt = sat24(psum);
        state_nxt   = bcu_pkg::ST_DONE;
      end
      bcu_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = cmd_r;
          out_value_nxt = res_err_r ? 24'd0 : res_val_r;
          out_err_nxt   = res_err_r;
          state_nxt     = bcu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bcu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcu_pkg::ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      temp_term_r <= '0;
      neg_r       <= 1'b0;
      dvd_r       <= '0;
      dvs_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      temp_term_r <= temp_term_nxt;
      neg_r       <= neg_nxt;
      dvd_r       <= dvd_nxt;
      dvs_r       <= dvs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    raw_r       <= raw_nxt;
    x1_r        <= x1_nxt;
    b6_r        <= b6_nxt;
    sq_r        <= sq_nxt;
    s1_r        <= s1_nxt;
    b3_r        <= b3_nxt;
    b4_r        <= b4_nxt;
    b7_r        <= b7_nxt;
    p_r         <= p_nxt;
    y1_r        <= y1_nxt;
    res_err_r   <= res_err_nxt;
    res_val_r   <= res_val_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_value     = out_value_r;
  assign out_div_error = out_err_r;

endmodule

/* hdl/bcu_serial_alu.sv */
// Bit-serial 32-bit multiplier (low word) and unsigned restoring divider.
`timescale 1ns / 1ps
module bcu_serial_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  bcu_pkg::alu_req_t req,
  input  logic [31:0]       opa,
  input  logic [31:0]       opb,
  output logic              done,
  output logic [31:0]       res
);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  bcu_pkg::alu_op_t op_r, op_nxt;
  logic [31:0]     a_r, a_nxt;
  logic [31:0]     b_r, b_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [32:0]     rem_sh;
  logic [32:0]     rem_diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    rem_sh   = {rem_r, a_r[31]};
    rem_diff = rem_sh - {1'b0, b_r};
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      op_nxt   = req.op;
      a_nxt    = opa;
      b_nxt    = opb;
      acc_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (op_r == bcu_pkg::OP_MUL) begin
        // add the shifted multiplicand for each set multiplier bit
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt = {a_r[30:0], 1'b0};
        b_nxt = {1'b0, b_r[31:1]};
      end else begin
        a_nxt = {a_r[30:0], 1'b0};
        if (!rem_diff[32]) begin
          rem_nxt = rem_diff[31:0];
          acc_nxt = {acc_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[31:0];
          acc_nxt = {acc_r[30:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= bcu_pkg::OP_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

/* hdl/bcu_checker.sv */
// Port-level checks for the compensation unit, bound to the top level.
`timescale 1ns / 1ps
module bcu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [23:0] out_value,
  input logic        out_div_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_kind))
    else $error("stalled result word changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_error |-> out_value == 24'd0)
    else $error("divide error with nonzero value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind barometric_sensor_compensation_unit bcu_checker u_bcu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_value     (out_value),
  .out_div_error (out_div_error)
);

/* verif/tb_barometric_sensor_compensation_unit.sv */
// Testbench for the barometric compensation unit: queued driver, predictor and result checker.
`timescale 1ns / 1ps
module tb_barometric_sensor_compensation_unit;

  localparam int OSS        = 3;
  localparam int SETTLE     = 40;
  localparam int CYCLE_CAP  = 3000000;

  typedef struct {
    logic        cmd;
    logic [18:0] raw;
  } sample_t;

  typedef struct {
    logic               kind;
    logic signed [23:0] value;
    logic               div_error;
  } reading_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_cmd;
  logic [18:0]        in_raw_sample;
  logic               out_valid;
  logic               out_stall;
  logic               out_kind;
  logic signed [23:0] out_value;
  logic               out_div_error;

  barometric_sensor_compensation_unit #(.OVERSAMPLING(OSS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_raw_sample(in_raw_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_value(out_value), .out_div_error(out_div_error)
  );

  // calibration copy and the kept B5 term
  logic [15:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_ac5, cal_ac6;
  logic [31:0] cal_b, cal_m;
  int          b5_term = 0;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  bit       calm;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int sat24(int v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // datasheet integer compensation; updates b5_term on good temperature words
  function automatic reading_t compensate(logic cmd, logic [18:0] raw);
    reading_t r;
    int ut, mc, md, x1, x2, x3, den, b5;
    int a1, a2, a3, b1, b2, b6, sq, b3, p, y1, y2;
    bit [31:0] t, b4, b7, pu;
    r.kind = cmd;
    r.value = '0;
    r.div_error = 1'b0;
    if (cmd == 1'b0) begin
      ut = raw[15:0];
      mc = $signed(cal_m[31:16]);
      md = $signed(cal_m[15:0]);
      x1 = ((ut - int'(cal_ac6)) * int'(cal_ac5)) >>> 15;
      den = x1 + md;
      if (den == 0) begin
        r.div_error = 1'b1;
      end else begin
        x2 = (mc * 2048) / den;
        b5 = x1 + x2;
        b5_term = b5;
        r.value = sat24((b5 + 8) >>> 4);
      end
    end else begin
      a1 = $signed(cal_ac1);
      a2 = $signed(cal_ac2);
      a3 = $signed(cal_ac3);
      b1 = $signed(cal_b[31:16]);
      b2 = $signed(cal_b[15:0]);
      b6 = b5_term - 4000;
      sq = (b6 * b6) >>> 12;
      x1 = (b2 * sq) >>> 11;
      x2 = (a2 * b6) >>> 11;
      x3 = x1 + x2;
      t = 32'(a1 * 4 + x3) << OSS;
      b3 = int'(t + 32'd2) >>> 2;
      x1 = (a3 * b6) >>> 13;
      x2 = (b1 * sq) >>> 16;
      x3 = (x1 + x2 + 2) >>> 2;
      b4 = (32'(cal_ac4) * (32'(x3) + 32'd32768)) >> 15;
      if (b4 == 0) begin
        r.div_error = 1'b1;
      end else begin
        b7 = (32'(raw) - 32'(b3)) * (32'd50000 >> OSS);
        if (b7 < 32'h8000_0000) pu = (b7 << 1) / b4;
        else pu = (b7 / b4) << 1;
        p = int'(pu);
        y1 = p >>> 8;
        y1 = y1 * y1;
        y1 = (y1 * 3038) >>> 16;
        y2 = (-7357 * p) >>> 16;
        p = p + ((y1 + y2 + 3791) >>> 4);
        r.value = sat24(p);
      end
    end
    return r;
  endfunction

  // driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_cmd <= 1'b0;
      in_raw_sample <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_readings.push_back(compensate(in_cmd, in_raw_sample));
      if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 18)) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_valid <= 1'b1;
        in_cmd <= s.cmd;
        in_raw_sample <= s.raw;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each accepted word against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word kind=%0d value=%0d err=%0d",
                   $time, out_kind, out_value, out_div_error);
        end else begin
          reading_t e;
          e = expected_readings.pop_front();
          if (e.kind !== out_kind || e.value !== out_value ||
              e.div_error !== out_div_error) begin
            mismatch_count++;
            $display("%0t: mismatch expected kind=%0d value=%0d err=%0d,",
                     $time, e.kind, e.value, e.div_error,
                     " actual kind=%0d value=%0d err=%0d",
                     out_kind, out_value, out_div_error);
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(bcu_pkg::reg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bcu_pkg::REG_AC1: cal_ac1 = data[15:0];
      bcu_pkg::REG_AC2: cal_ac2 = data[15:0];
      bcu_pkg::REG_AC3: cal_ac3 = data[15:0];
      bcu_pkg::REG_AC4: cal_ac4 = data[15:0];
      bcu_pkg::REG_AC5: cal_ac5 = data[15:0];
      bcu_pkg::REG_AC6: cal_ac6 = data[15:0];
      bcu_pkg::REG_B:   cal_b = data;
      default: cal_m = data;
    endcase
  endtask

  task automatic load_calibration(logic [15:0] a1, a2, a3, a4, a5, a6, logic [31:0] bw, mw);
    write_reg(bcu_pkg::REG_AC1, {16'h0, a1});
    write_reg(bcu_pkg::REG_AC2, {16'h0, a2});
    write_reg(bcu_pkg::REG_AC3, {16'h0, a3});
    write_reg(bcu_pkg::REG_AC4, {16'h0, a4});
    write_reg(bcu_pkg::REG_AC5, {16'h0, a5});
    write_reg(bcu_pkg::REG_AC6, {16'h0, a6});
    write_reg(bcu_pkg::REG_B, bw);
    write_reg(bcu_pkg::REG_M, mw);
  endtask

  task automatic queue_word(logic cmd, logic [18:0] raw);
    sample_t s;
    s.cmd = cmd;
    s.raw = raw;
    pending_samples.push_back(s);
  endtask

  // hold until every queued word is through and the unit is quiet
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // datasheet-like calibration, optionally jittered
  task automatic typical_calibration(bit jitter);
    int j;
    j = jitter ? 200 : 0;
    load_calibration(16'(408 + $urandom_range(2 * j) - j),
                     16'(-72 + $urandom_range(2 * j) - j),
                     16'(-14383 + $urandom_range(2 * j) - j),
                     16'(32741 - $urandom_range(2 * j)), 16'(32757 - $urandom_range(2 * j)),
                     16'(23153 + $urandom_range(2 * j) - j),
                     {16'(6190 + $urandom_range(j)), 16'(4 + $urandom_range(j / 20))},
                     {16'(-8711 + $urandom_range(2 * j) - j), 16'(2868 + $urandom_range(j))});
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        queue_word(1'($urandom_range(1)), 19'($urandom));
      end else begin
        // well-formed pair: temperature first, then pressure
        queue_word(1'b0, 19'($urandom_range(40000, 20000)));
        queue_word(1'b1, 19'($urandom_range(420000, 150000)));
        i++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    {cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_ac5, cal_ac6} = '0;
    cal_b = '0;
    cal_m = '0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: both divisors are zero
    queue_word(1'b0, 19'd27898);
    queue_word(1'b1, 19'h7FFFF);
    drain();

    typical_calibration(1'b0);
    queue_word(1'b1, 19'd190744);   // pressure before any good temperature
    queue_word(1'b0, 19'd27898);
    queue_word(1'b1, 19'd190744);
    queue_word(1'b0, 19'h7FFFF);    // upper bits beyond the 16-bit reading
    queue_word(1'b0, 19'd0);
    queue_word(1'b1, 19'd0);
    queue_word(1'b1, 19'h7FFFF);
    queue_word(1'b0, 19'h70000);
    queue_word(1'b1, 19'h40000);
    drain();

    // temperature divisor zero keeps the old term
    load_calibration(cal_ac1, cal_ac2, cal_ac3, cal_ac4, 16'd0, cal_ac6, cal_b, 32'hABCD_0000);
    queue_word(1'b0, 19'd30000);
    queue_word(1'b1, 19'd200000);
    drain();

    // extremes
    load_calibration(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     32'h7FFF_7FFF, 32'h7FFF_7FFF);
    queue_word(1'b0, 19'hFFFF);
    queue_word(1'b1, 19'h7FFFF);
    queue_word(1'b0, 19'd0);
    queue_word(1'b1, 19'd1);
    random_words(30);
    drain();
    load_calibration(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0001, 16'h0000,
                     32'h8000_8000, 32'h8000_8000);
    queue_word(1'b0, 19'hFFFF);
    queue_word(1'b1, 19'h7FFFF);
    random_words(30);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 2);
      case (ph % 4)
        0: typical_calibration(1'b0);
        1, 2: typical_calibration(1'b1);
        default: load_calibration(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), $urandom, $urandom);
      endcase
      random_words(152);
      drain();
    end
    calm = 1'b0;

    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
